// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/hcbp_pkg.sv =====
// ----------------------------------------------------------------------------
// hcbp_pkg
// Shared types and constants of the Huffman code bit packer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hcbp_pkg;

	localparam int ALPHABET_SIZE = 256;
	localparam int MAX_CODE_LEN  = 24;

	localparam int SYM_W   = 8;
	localparam int WORD_W  = 24;
	localparam int LEN_W   = 5;
	localparam int KIND_W  = 2;
	localparam int BYTE_W  = 8;
	localparam int IDX_W   = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;

	// leftover bits between items never reach a full byte
	localparam int ACC_W   = BYTE_W - 1;
	localparam int PEND_W  = $clog2(BYTE_W);
	localparam int CMB_W   = ACC_W + MAX_CODE_LEN;
	localparam int TOT_W   = $clog2(CMB_W + 1);
	localparam int MAX_BYTES = CMB_W / BYTE_W;
	localparam int CNT_W   = $clog2(MAX_BYTES + 1);

	typedef enum logic [KIND_W-1:0] {
		KIND_LOAD   = 2'd0,
		KIND_ENCODE = 2'd1,
		KIND_FLUSH  = 2'd2
	} kind_t;

	typedef struct packed {
		logic [LEN_W-1:0]  len;
		logic [WORD_W-1:0] word;
	} cb_entry_t;

endpackage

`default_nettype wire

// ===== src/huffman_code_bit_packer.sv =====
// Path: an encode or flush beat is registered in stage 1, then loads the byte buffer.
// Throughput: 1 beat per cycle for loads and for codes that complete no byte; an
//   item that yields bytes (up to 3) holds the input until the byte buffer is
//   free, as the one-byte output channel drains it and m_tready can stall it.
// Reset: accumulator and all code lengths clear at once (per-entry valid flops);
//   code words stay undefined until loaded.
// ----------------------------------------------------------------------------
// huffman_code_bit_packer
// Codebook RAM lookup plus MSB-first bit accumulator and byte emitter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module huffman_code_bit_packer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [39:0] s_tdata,   // symbol[7:0], code_word[31:8], code_length[36:32]
	input  wire logic [1:0]  s_tuser,   // kind[1:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,   // out_byte[7:0]
	output logic             m_tlast,
	output logic [0:0]       m_tuser    // final_byte[0]
);

	localparam int EM_W = hcbp_pkg::CMB_W;

	// input unpack
	hcbp_pkg::kind_t                  in_kind;
	logic [hcbp_pkg::SYM_W-1:0]       in_sym;
	logic [hcbp_pkg::WORD_W-1:0]      in_word;
	logic [hcbp_pkg::LEN_W-1:0]       in_len;
	logic [hcbp_pkg::LEN_W-1:0]       len_c;
	logic [hcbp_pkg::WORD_W-1:0]      word_mask;
	logic [hcbp_pkg::IDX_W-1:0]       idx;
	logic                             in_range;
	logic                             accept;
	logic                             do_load;

	assign in_kind = hcbp_pkg::kind_t'(s_tuser);
	assign in_sym  = s_tdata[7:0];
	assign in_word = s_tdata[31:8];
	assign in_len  = s_tdata[36:32];
	assign idx     = in_sym[hcbp_pkg::IDX_W-1:0];
	assign in_range = {1'b0, in_sym} < 9'(hcbp_pkg::ALPHABET_SIZE);
	assign len_c   = (in_len > hcbp_pkg::LEN_W'(hcbp_pkg::MAX_CODE_LEN)) ?
		hcbp_pkg::LEN_W'(hcbp_pkg::MAX_CODE_LEN) : in_len;
	assign word_mask = hcbp_pkg::WORD_W'(((hcbp_pkg::WORD_W+2)'(1) << len_c)
		- (hcbp_pkg::WORD_W+2)'(1));
	assign accept  = s_tvalid && s_tready;
	assign do_load = accept && (in_kind == hcbp_pkg::KIND_LOAD) && in_range;

	// codebook RAM, one write and one registered read per cycle, on an accepted input beat
	hcbp_pkg::cb_entry_t cb_mem [hcbp_pkg::ALPHABET_SIZE];
	logic [hcbp_pkg::ALPHABET_SIZE-1:0] len_vld_q;

	// stage 1: lookup result
	logic                  valid_s1;
	hcbp_pkg::kind_t       kind_s1;
	logic                  range_s1;
	logic                  hit_s1;
	hcbp_pkg::cb_entry_t   ent_s1;

	always_ff @(posedge clk) begin
		if (do_load) begin
			cb_mem[idx] <= '{len: len_c, word: in_word & word_mask};
		end
		if (accept) begin
			ent_s1   <= cb_mem[idx];
			hit_s1   <= len_vld_q[idx];
			kind_s1  <= in_kind;
			range_s1 <= in_range;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_vld_q <= '0;
		end else if (do_load) begin
			len_vld_q[idx] <= 1'b1;
		end
	end

	// accumulator and emitter state
	logic [hcbp_pkg::ACC_W-1:0]  acc_q;
	logic [hcbp_pkg::PEND_W-1:0] pend_q;
	logic [EM_W-1:0]             em_q;
	logic [hcbp_pkg::CNT_W-1:0]  em_cnt_q;
	logic                        em_fin_q;

	logic [hcbp_pkg::LEN_W-1:0]  clen;
	logic [hcbp_pkg::CMB_W-1:0]  combined;
	logic [hcbp_pkg::TOT_W-1:0]  total;
	logic [hcbp_pkg::TOT_W:0]    align_sh;
	logic [hcbp_pkg::BYTE_W-1:0] flush_byte;
	logic [hcbp_pkg::BYTE_W-1:0] pend_mask;

	logic [hcbp_pkg::CNT_W-1:0]  nb;
	logic [EM_W-1:0]             em_load;
	logic                        fin_load;
	logic [hcbp_pkg::ACC_W-1:0]  acc_d;
	logic [hcbp_pkg::PEND_W-1:0] pend_d;
	logic                        em_free;
	logic                        advance;
	logic                        out_hs;

	// an entry never loaded has no word; its length reads as zero
	assign clen     = hit_s1 ? ent_s1.len : '0;
	assign combined = (hcbp_pkg::CMB_W'(acc_q) << clen)
		| (hit_s1 ? hcbp_pkg::CMB_W'(ent_s1.word) : '0);
	assign total    = hcbp_pkg::TOT_W'(pend_q) + hcbp_pkg::TOT_W'(clen);
	assign align_sh = (hcbp_pkg::TOT_W+1)'(EM_W) - (hcbp_pkg::TOT_W+1)'(total);
	assign pend_mask = (hcbp_pkg::BYTE_W'(1) << total[hcbp_pkg::PEND_W-1:0])
		- hcbp_pkg::BYTE_W'(1);
	assign flush_byte = hcbp_pkg::BYTE_W'({1'b0, acc_q}
		<< (4'd8 - 4'(pend_q)));

	always_comb begin
		nb       = '0;
		em_load  = '0;
		fin_load = 1'b0;
		acc_d    = acc_q;
		pend_d   = pend_q;
		case (kind_s1)
			hcbp_pkg::KIND_ENCODE: begin
				if (range_s1) begin
					nb      = hcbp_pkg::CNT_W'(total >> 3);
					em_load = EM_W'(combined) << align_sh;
					pend_d  = total[hcbp_pkg::PEND_W-1:0];
					acc_d   = combined[hcbp_pkg::ACC_W-1:0] & pend_mask[hcbp_pkg::ACC_W-1:0];
				end
			end
			hcbp_pkg::KIND_FLUSH: begin
				nb       = (pend_q != '0) ? hcbp_pkg::CNT_W'(1) : '0;
				em_load  = {flush_byte, (EM_W-hcbp_pkg::BYTE_W)'(0)};
				fin_load = 1'b1;
				acc_d    = '0;
				pend_d   = '0;
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = (em_cnt_q != '0);
	assign m_tdata  = em_q[EM_W-1 -: hcbp_pkg::BYTE_W];
	assign m_tlast  = (em_cnt_q == hcbp_pkg::CNT_W'(1));
	assign m_tuser  = em_fin_q;
	assign out_hs   = m_tvalid && m_tready;

	// buffer takes a new item when empty or once its last byte goes out this cycle
	assign em_free  = (em_cnt_q == '0) || (m_tlast && m_tready);
	assign advance  = valid_s1 && ((nb == '0) || em_free);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			acc_q    <= '0;
			pend_q   <= '0;
			em_cnt_q <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				acc_q  <= acc_d;
				pend_q <= pend_d;
			end
			if (advance && (nb != '0)) begin
				em_cnt_q <= nb;
			end else if (out_hs) begin
				em_cnt_q <= em_cnt_q - hcbp_pkg::CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && (nb != '0)) begin
			em_q     <= em_load;
			em_fin_q <= fin_load;
		end else if (out_hs) begin
			em_q <= em_q << hcbp_pkg::BYTE_W;
		end
	end

endmodule

`default_nettype wire

// ===== src/hcbp_checker.sv =====
// ----------------------------------------------------------------------------
// hcbp_checker
// Port-level checks on the output channel of the bit packer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module hcbp_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic [39:0] s_tdata,
	input wire logic [1:0]  s_tuser,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [7:0]  m_tdata,
	input wire logic        m_tlast,
	input wire logic [0:0]  m_tuser
);

	logic in_beat;
	logic load_beat;
	logic out_stall;
	logic out_more;
	assign in_beat   = s_tvalid && s_tready;
	assign load_beat = in_beat && s_tdata[39:37] == 3'd0
		&& s_tuser == hcbp_pkg::KIND_LOAD;
	assign out_stall = m_tvalid && !m_tready;
	assign out_more  = m_tvalid && m_tready && !m_tlast;

	`ASSERT_NEXT(a_out_hold, out_stall, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "held beat changed")

	// the padded closing byte is a flush's only byte
	`ASSERT_NOW(a_final_is_last, m_tvalid && m_tuser[0], m_tlast, "final byte without tlast")

	// bytes of one item leave without gaps
	`ASSERT_NEXT(a_burst_gapless, out_more, m_tvalid, "gap inside an item's bytes")

	// a load with nothing ahead of it never puts anything on the output
	`ASSERT_NEXT(a_load_silent, load_beat && !m_tvalid && !$past(in_beat), !m_tvalid, "load gave output")

endmodule

bind huffman_code_bit_packer hcbp_checker u_hcbp_checker (.*);

`default_nettype wire

// ===== tb/huffman_code_bit_packer_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_code_bit_packer_test
// Self-checking bench for the Huffman code bit packer. Loads codebook entries,
// encodes symbols and flushes, and checks every output beat against a
// scoreboard that tracks the codebook and the pending bits.
// ----------------------------------------------------------------------------

module huffman_code_bit_packer_test;

	localparam logic [hcbp_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 200000;
	localparam int TAIL_CYCLES = 12;
	localparam int ITEMS_PER_PHASE = 110;

	typedef struct packed {
		logic [hcbp_pkg::BYTE_W-1:0] data;
		logic                        lst;
		logic                        fin;
	} out_beat_t;

	class packed_byte_scoreboard;
		logic [hcbp_pkg::WORD_W-1:0] cb_word [hcbp_pkg::ALPHABET_SIZE];
		logic [hcbp_pkg::LEN_W-1:0]  cb_len [hcbp_pkg::ALPHABET_SIZE];
		logic [31:0]       acc;
		int unsigned       pend;
		out_beat_t         expected_bytes[$];
		int unsigned       n_errors, n_items, n_bytes, n_closing;

		function new();
			for (int i = 0; i < hcbp_pkg::ALPHABET_SIZE; i++) begin
				cb_word[i] = '0;
				cb_len[i]  = '0;
			end
			acc       = '0;
			pend      = 0;
			n_errors  = 0;
			n_items   = 0;
			n_bytes   = 0;
			n_closing = 0;
		endfunction

		task report_mismatch(string what);
			$display("[%0t] MISMATCH: %s", $time, what);
			n_errors++;
		endtask

		// accepted input beat: update the codebook / accumulator, queue the bytes
		function void note_beat(logic [hcbp_pkg::KIND_W-1:0] kind,
				logic [hcbp_pkg::SYM_W-1:0] sym,
				logic [hcbp_pkg::WORD_W-1:0] word, logic [hcbp_pkg::LEN_W-1:0] len);
			int unsigned clen, total, nb;
			logic [31:0] bits;
			out_beat_t ob;
			n_items++;
			case (kind)
			hcbp_pkg::KIND_LOAD: begin
				cb_word[sym] = word;
				cb_len[sym]  = (len > hcbp_pkg::MAX_CODE_LEN) ?
					hcbp_pkg::LEN_W'(hcbp_pkg::MAX_CODE_LEN) : len;
			end
			hcbp_pkg::KIND_ENCODE: begin
				clen = cb_len[sym];
				if (clen != 0) begin
					// stray bits above the length are masked off
					bits  = 32'(cb_word[sym]) & ((32'd1 << clen) - 32'd1);
					acc   = (acc << clen) | bits;
					total = pend + clen;
					nb    = total / 8;
					for (int unsigned k = 0; k < nb; k++) begin
						ob.data = hcbp_pkg::BYTE_W'(acc >> (total - 8 * (k + 1)));
						ob.lst  = (k == nb - 1);
						ob.fin  = 1'b0;
						expected_bytes.push_back(ob);
					end
					pend = total % 8;
					acc  = acc & ((32'd1 << pend) - 32'd1);
				end
			end
			hcbp_pkg::KIND_FLUSH: begin
				if (pend != 0) begin
					ob.data = hcbp_pkg::BYTE_W'(acc << (8 - pend));
					ob.lst  = 1'b1;
					ob.fin  = 1'b1;
					expected_bytes.push_back(ob);
				end
				acc  = '0;
				pend = 0;
			end
			default: ;
			endcase
		endfunction

		task check_byte(logic [hcbp_pkg::BYTE_W-1:0] data, logic lst, logic fin);
			out_beat_t ob;
			if (expected_bytes.size() == 0) begin
				report_mismatch($sformatf("byte %02h last=%0b final=%0b with nothing expected",
					data, lst, fin));
			end else begin
				ob = expected_bytes.pop_front();
				n_bytes++;
				if (ob.fin)
					n_closing++;
				if (data !== ob.data)
					report_mismatch($sformatf("out_byte %02h, expected %02h", data, ob.data));
				if (lst !== ob.lst)
					report_mismatch($sformatf("last %0b, expected %0b (byte %02h)",
						lst, ob.lst, ob.data));
				if (fin !== ob.fin)
					report_mismatch($sformatf("final_byte %0b, expected %0b (byte %02h)",
						fin, ob.fin, ob.data));
			end
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;
	logic        m_tlast;
	logic [0:0]  m_tuser;

	packed_byte_scoreboard byte_sb;
	int unsigned cycles;
	int unsigned send_idle_pct;
	int unsigned sink_stall_pct;
	logic [hcbp_pkg::SYM_W-1:0] live_syms[$];

	huffman_code_bit_packer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
	end

	always #10 clk = ~clk;

	always @(negedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
	end

	// note inputs before checking outputs so a same-edge beat is never early
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				byte_sb.note_beat(s_tuser, s_tdata[7:0], s_tdata[31:8], s_tdata[36:32]);
			if (m_tvalid && m_tready)
				byte_sb.check_byte(m_tdata, m_tlast, m_tuser[0]);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d bytes still expected", cycles,
				byte_sb.expected_bytes.size());
			$display("Some tests failed");
			$finish;
		end
	end

	task send_item(logic [hcbp_pkg::KIND_W-1:0] kind, logic [hcbp_pkg::SYM_W-1:0] sym,
			logic [hcbp_pkg::WORD_W-1:0] word, logic [hcbp_pkg::LEN_W-1:0] len);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {3'b000, len, word, sym};
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	// hold off the sender until every queued byte has been seen
	task drain_output();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (byte_sb.expected_bytes.size() != 0)
			@(negedge clk);
	endtask

	task run_directed();
		send_item(hcbp_pkg::KIND_ENCODE, 8'd0, 24'hFFFFFF, 5'd31);   // empty codebook entry
		send_item(hcbp_pkg::KIND_FLUSH, 8'd0, 24'h000000, 5'd0);     // nothing pending
		send_item(KIND_UNUSED, 8'hFF, 24'hFFFFFF, 5'd31);
		send_item(hcbp_pkg::KIND_LOAD, 8'd0, 24'hFFFFFF, 5'd24);
		send_item(hcbp_pkg::KIND_LOAD, 8'd255, 24'h000001, 5'd1);
		send_item(hcbp_pkg::KIND_LOAD, 8'd1, 24'hFFFFFD, 5'd3);      // stray upper bits
		send_item(hcbp_pkg::KIND_LOAD, 8'd2, 24'hABCDEF, 5'd31);     // clamps to max length
		send_item(hcbp_pkg::KIND_LOAD, 8'd3, 24'h123456, 5'd0);      // absent symbol
		send_item(hcbp_pkg::KIND_LOAD, 8'd128, 24'h000000, 5'd8);
		send_item(hcbp_pkg::KIND_ENCODE, 8'd255, 24'h000000, 5'd0);
		send_item(hcbp_pkg::KIND_ENCODE, 8'd0, 24'h000000, 5'd0);    // 25 bits -> 3 bytes
		send_item(hcbp_pkg::KIND_ENCODE, 8'd1, 24'h000000, 5'd0);
		send_item(hcbp_pkg::KIND_ENCODE, 8'd3, 24'hFFFFFF, 5'd31);
		send_item(hcbp_pkg::KIND_ENCODE, 8'd1, 24'h000000, 5'd0);    // 7 bits pending
		send_item(hcbp_pkg::KIND_ENCODE, 8'd2, 24'h000000, 5'd0);    // 31 bits combined
		send_item(hcbp_pkg::KIND_FLUSH, 8'hFF, 24'hFFFFFF, 5'd31);
		send_item(hcbp_pkg::KIND_FLUSH, 8'd0, 24'h000000, 5'd0);
		send_item(hcbp_pkg::KIND_ENCODE, 8'd0, 24'h000000, 5'd0);    // exact 3 bytes
		send_item(hcbp_pkg::KIND_FLUSH, 8'd0, 24'h000000, 5'd0);
		send_item(hcbp_pkg::KIND_ENCODE, 8'd128, 24'h000000, 5'd0);
		send_item(hcbp_pkg::KIND_LOAD, 8'd255, 24'h555555, 5'd25);
		send_item(hcbp_pkg::KIND_ENCODE, 8'd255, 24'h000000, 5'd0);
		send_item(hcbp_pkg::KIND_ENCODE, 8'd255, 24'h000000, 5'd0);
		send_item(hcbp_pkg::KIND_FLUSH, 8'd0, 24'h000000, 5'd0);
	endtask

	task run_random(int unsigned n_useful);
		int unsigned done_cnt, r;
		logic [hcbp_pkg::SYM_W-1:0]  sym;
		logic [hcbp_pkg::LEN_W-1:0]  len;
		logic [hcbp_pkg::WORD_W-1:0] word;
		done_cnt = 0;
		while (done_cnt < n_useful) begin
			r    = $urandom_range(0, 99);
			sym  = hcbp_pkg::SYM_W'($urandom_range(0, hcbp_pkg::ALPHABET_SIZE - 1));
			word = hcbp_pkg::WORD_W'($urandom());
			len  = hcbp_pkg::LEN_W'($urandom());
			if (r < 12) begin
				if ($urandom_range(0, 1))
					sym = hcbp_pkg::SYM_W'($urandom_range(0, 15));
				r = $urandom_range(0, 99);
				if (r < 5)
					len = '0;
				else if (r < 12)
					len = hcbp_pkg::LEN_W'($urandom_range(hcbp_pkg::MAX_CODE_LEN + 1, 31));
				else
					len = hcbp_pkg::LEN_W'($urandom_range(1, hcbp_pkg::MAX_CODE_LEN));
				if (len != 0)
					live_syms.push_back(sym);
				send_item(hcbp_pkg::KIND_LOAD, sym, word, len);
				done_cnt++;
			end else if (r < 82) begin
				if (live_syms.size() != 0 && $urandom_range(0, 99) < 85)
					sym = live_syms[$urandom_range(0, live_syms.size() - 1)];
				send_item(hcbp_pkg::KIND_ENCODE, sym, word, len);
				done_cnt++;
			end else if (r < 94) begin
				send_item(hcbp_pkg::KIND_FLUSH, sym, word, len);
				done_cnt++;
			end else begin
				send_item(KIND_UNUSED, sym, word, len);
			end
		end
	endtask

	initial begin
		byte_sb        = new();
		cycles         = 0;
		arst_n         = 1'b0;
		s_tvalid       = 1'b0;
		s_tdata        = '0;
		s_tuser        = '0;
		m_tready       = 1'b0;
		send_idle_pct  = 12;
		sink_stall_pct = 67;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		run_directed();
		drain_output();
		run_random(ITEMS_PER_PHASE);
		drain_output();

		send_idle_pct  = 67;
		sink_stall_pct = 12;
		run_random(ITEMS_PER_PHASE);
		drain_output();

		send_idle_pct  = 0;
		sink_stall_pct = 0;
		run_random(ITEMS_PER_PHASE);
		drain_output();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Covered %0d input beats (loads, encodes, flushes, unused kind) under three",
			byte_sb.n_items);
		$display("idle/stall mixes; %0d output bytes checked, %0d closing bytes from flush",
			byte_sb.n_bytes, byte_sb.n_closing);
		if (byte_sb.n_errors == 0 && byte_sb.expected_bytes.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+src
src/hcbp_pkg.sv
src/huffman_code_bit_packer.sv
src/hcbp_checker.sv
tb/huffman_code_bit_packer_test.sv
